@@ rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants for the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

   // map memory word geometry
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;

   // item field widths
   localparam int CMD_W      = 2;
   localparam int ID_W       = 10;
   localparam int STATUS_W   = 3;
   localparam int GRANT_W    = 9;
   localparam int COUNT_W    = 10;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // width for range compares against block parameters
   localparam int WIDE_W     = 18;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_REQUEST = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_RANGE    = 3'd2,
      ST_USED     = 3'd3,
      ST_RESERVED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_LOOKUP,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       rd_first;
      logic       rd_next;
      logic       rd_id;
      logic       init_wr;
      logic       alloc_wr;
      logic       set_wr;
      logic       clr_wr;
      logic       set_res;
      status_type res_code;
      logic       out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad_range;
      logic is_alloc;
      logic is_release;
      logic rel_reserved;
      logic hit;
      logic last_word;
      logic map_bit;
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/bba_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_datapath
// used map memory, first-zero search, counters and result register
// ----------------------------------------------------------------------------
module bba_datapath #(
   parameter int NUM_BLOCKS     = 512,
   parameter int RESERVED_START = 0,
   parameter int RESERVED_COUNT = 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [bba_pkg::CMD_W-1:0]     req_cmd,
   input  wire [bba_pkg::ID_W-1:0]      req_blk_idx,
   input  bba_pkg::dp_cmd_type          cmd,
   output bba_pkg::dp_status_type       status,
   output logic [bba_pkg::RSP_DATA_W-1:0] rsp_data
);
   import bba_pkg::*;

   localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
   localparam int RES_LO    = RESERVED_START;
   localparam int RES_HI    = RESERVED_START + RESERVED_COUNT;
   localparam int RES_TOP   = (RES_HI < NUM_BLOCKS) ? RES_HI : NUM_BLOCKS;
   localparam int RES_USED  = (RES_TOP > RES_LO) ? (RES_TOP - RES_LO) : 0;

   localparam logic [WIDE_W-1:0] NB_W      = WIDE_W'(NUM_BLOCKS);
   localparam logic [WIDE_W-1:0] LO_W      = WIDE_W'(RES_LO);
   localparam logic [WIDE_W-1:0] HI_W      = WIDE_W'(RES_HI);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(NUM_WORDS - 1);

   logic [WORD_W-1:0] map_mem [NUM_WORDS];

   cmd_type              cmd_ff;
   logic [ID_W-1:0]      id_ff;
   logic [AW-1:0]        addr_ff;
   logic [WORD_W-1:0]    rdata_ff;
   logic [CNT_W-1:0]     used_total_ff;
   logic [GRANT_W-1:0]   grant_ff;
   status_type           status_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_data;
   logic [WORD_W-1:0]    init_word;
   logic                 hit;
   logic [BIT_W-1:0]     pos;
   logic [WORD_W-1:0]    pos_mask;
   logic [WORD_W-1:0]    id_mask;
   logic [WIDE_W-1:0]    id_wide;
   logic [AW-1:0]        id_word;
   logic [WIDE_W-1:0]    used_wide;
   logic [WIDE_W-1:0]    free_wide;

   assign id_wide  = WIDE_W'(id_ff);
   assign id_word  = AW'(id_ff[ID_W-1:BIT_W]);
   assign id_mask  = WORD_W'(1) << id_ff[BIT_W-1:0];
   assign pos_mask = WORD_W'(1) << pos;

   // reset image of a word: reserved blocks and blocks past the end read as used
   always_comb begin
      logic [WIDE_W-1:0] idx;
      init_word = '0;
      for (int b = 0; b < WORD_W; b++) begin
         idx = WIDE_W'({addr_ff, BIT_W'(b)});
         init_word[b] = (idx >= NB_W) || ((idx >= LO_W) && (idx < HI_W));
      end
   end

   // lowest clear bit of the word just read
   always_comb begin
      hit = 1'b0;
      pos = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!rdata_ff[b]) begin
            hit = 1'b1;
            pos = BIT_W'(b);
         end
      end
   end

   always_comb begin
      status.is_alloc     = (cmd_ff == CMD_ALLOC);
      status.is_release   = (cmd_ff == CMD_RELEASE);
      status.rel_reserved = (cmd_ff == CMD_RELEASE) && (id_wide >= LO_W) && (id_wide < HI_W);
      status.hit          = hit;
      status.last_word    = (addr_ff == LAST_ADDR);
      status.map_bit      = rdata_ff[id_ff[BIT_W-1:0]];
      case (cmd_ff)
         CMD_ALLOC:   status.bad_range = 1'b0;
         CMD_REQUEST: status.bad_range = (id_wide >= NB_W);
         CMD_RELEASE: status.bad_range = (id_wide >= NB_W);
         default:     status.bad_range = 1'b1;
      endcase
   end

   // read port address
   always_comb begin
      rd_en = cmd.rd_first | cmd.rd_next | cmd.rd_id;
      if (cmd.rd_first) begin
         rd_addr = '0;
      end else if (cmd.rd_next) begin
         rd_addr = addr_ff + AW'(1);
      end else begin
         rd_addr = id_word;
      end
   end

   // write port data, always at the word last addressed
   always_comb begin
      wr_en = cmd.init_wr | cmd.alloc_wr | cmd.set_wr | cmd.clr_wr;
      if (cmd.init_wr) begin
         wr_data = init_word;
      end else if (cmd.alloc_wr) begin
         wr_data = rdata_ff | pos_mask;
      end else if (cmd.set_wr) begin
         wr_data = rdata_ff | id_mask;
      end else begin
         wr_data = rdata_ff & ~id_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= map_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         used_total_ff <= CNT_W'(RES_USED);
      end else begin
         if (rd_en) begin
            addr_ff <= rd_addr;
         end else if (cmd.init_wr) begin
            addr_ff <= addr_ff + AW'(1);
         end
         if (cmd.alloc_wr || cmd.set_wr) begin
            used_total_ff <= used_total_ff + CNT_W'(1);
         end else if (cmd.clr_wr) begin
            used_total_ff <= used_total_ff - CNT_W'(1);
         end
      end
   end

   assign used_wide = WIDE_W'(used_total_ff);
   assign free_wide = NB_W - used_wide;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= cmd_type'(req_cmd);
         id_ff    <= req_blk_idx;
         grant_ff <= '0;
      end else if (cmd.alloc_wr) begin
         grant_ff <= GRANT_W'({addr_ff, pos});
      end
      if (cmd.set_res) begin
         status_ff <= cmd.res_code;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {free_wide[COUNT_W-1:0], used_wide[COUNT_W-1:0], grant_ff, status_ff};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/bba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer: clearing pass, decode, map scan, lookup, result hand-off
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   input  bba_pkg::dp_status_type  status,
   output bba_pkg::dp_cmd_type     cmd
);
   import bba_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.last_word) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.bad_range) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_RANGE;
               state_in     = S_DONE;
            end else if (status.is_alloc) begin
               cmd.rd_first = 1'b1;
               state_in     = S_SCAN;
            end else if (status.rel_reserved) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_RESERVED;
               state_in     = S_DONE;
            end else begin
               cmd.rd_id = 1'b1;
               state_in  = S_LOOKUP;
            end
         end
         S_SCAN: begin
            if (status.hit) begin
               cmd.alloc_wr = 1'b1;
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_OK;
               state_in     = S_DONE;
            end else if (status.last_word) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_FULL;
               state_in     = S_DONE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_LOOKUP: begin
            cmd.set_res = 1'b1;
            if (status.is_release) begin
               cmd.clr_wr   = status.map_bit;
               cmd.res_code = ST_OK;
            end else if (status.map_bit) begin
               cmd.res_code = ST_USED;
            end else begin
               cmd.set_wr   = 1'b1;
               cmd.res_code = ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ rtl/bitmap_block_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// first-fit block allocator over a one-bit-per-block used map
// ----------------------------------------------------------------------------
// Keeps one used bit per block for NUM_BLOCKS blocks in a map memory of 32-bit
// words, plus a running used count. Each request item carries a command
// (allocate lowest free block, request a named block, release a named block)
// and produces exactly one response item with status, granted block and the
// used and free counts after the operation. After reset the block runs a
// clearing pass that writes every map word once, marking the reserved blocks
// used; req_tready stays low until it ends. An in-range request or release
// is answered after a lookup of its map word; an out-of-range block, a
// release of a reserved block or the unused command code is answered from
// the decode step. Items are taken one at a time: the next item is accepted
// only once the response of the current one is loaded. Allocate scans the
// map one memory word per cycle from word 0 until it finds a free block or
// has read the last word, a full map included; it reads one word at a time
// because the map memory has a single read port. A finished response waits
// in an output register, so the next request is accepted while it is still
// pending; the pipeline only stalls when a second response is ready before
// the first was taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
   parameter int NUM_BLOCKS     = 512,
   parameter int RESERVED_START = 0,
   parameter int RESERVED_COUNT = 1
) (
   input  wire                                clock,
   input  wire                                reset,
   // request item
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [1:0] cmd, [11:2] block index, [15:12] zero
   input  wire  [bba_pkg::REQ_DATA_W-1:0]     req_tdata,
   // response item
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [2:0] status, [11:3] granted_block, [21:12] used_count, [31:22] free_count
   output logic [bba_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import bba_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: owns the state machine and the response valid flag
   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // map memory, search, counters and response payload
   bba_datapath #(
      .NUM_BLOCKS     (NUM_BLOCKS),
      .RESERVED_START (RESERVED_START),
      .RESERVED_COUNT (RESERVED_COUNT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_cmd      (req_tdata[CMD_W-1:0]),
      .req_blk_idx  (req_tdata[CMD_W+ID_W-1:CMD_W]),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .rsp_data     (rsp_tdata)
   );

endmodule
`default_nettype wire

@@ rtl/bba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
module bba_checker #(
   parameter int NUM_BLOCKS = 512
) (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [bba_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import bba_pkg::*;

   localparam logic [COUNT_W-1:0] NB_LOW = COUNT_W'(NUM_BLOCKS);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one item at a time: no back-to-back acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // status code is a defined one
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'(ST_RESERVED))
      else $error("undefined status code");

   // used and free always add up to the block count
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> COUNT_W'(rsp_tdata[21:12] + rsp_tdata[31:22]) == NB_LOW)
      else $error("used and free counts disagree");

   // only a successful operation may carry a granted block
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != 3'(ST_OK)) |-> rsp_tdata[11:3] == '0)
      else $error("granted block on failed item");

endmodule

bind bitmap_block_allocator_unit bba_checker #(
   .NUM_BLOCKS (NUM_BLOCKS)
) u_bba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bitmap block allocator unit
// ----------------------------------------------------------------------------
// A queue of command items is built up front: a short directed list that hits
// the reserved block, the range limits and the unused command code. After it
// come random phases that fill the map with allocates so that allocate reports full, then drain
// it with releases, then mix everything. A shadow used map predicts every
// response, and each response is checked field by field in order. The sender
// works in bursts with random gaps. The receiver stalls in changing modes.
// ----------------------------------------------------------------------------
module tb;
   import bba_pkg::*;

   localparam int NUM_BLK        = 512;
   localparam int RES_FIRST      = 0;
   localparam int RES_COUNT      = 1;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int ID_MAX         = (1 << ID_W) - 1;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic             hold;   // wait until every response is back
      logic [CMD_W-1:0] op;
      logic [ID_W-1:0]  id;
   } cmd_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [GRANT_W-1:0]  granted;
      logic [COUNT_W-1:0]  used;
      logic [COUNT_W-1:0]  free;
   } alloc_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   cmd_item_type  cmd_backlog[$];
   alloc_rsp_type awaited_rsp[$];

   logic [NUM_BLK-1:0] shadow_map;
   int                 shadow_used;
   logic               req_taken = 1'b0;
   int                 fail_count = 0;
   int                 idle_cycles = 0;
   int                 cmds_sent = 0;
   int                 rsps_seen = 0;
   int                 status_seen[5] = '{default: 0};

   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_span = 0;

   bitmap_block_allocator_unit #(
      .NUM_BLOCKS(NUM_BLK),
      .RESERVED_START(RES_FIRST),
      .RESERVED_COUNT(RES_COUNT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic is_reserved_blk(input int b);
      return (b >= RES_FIRST) && (b < RES_FIRST + RES_COUNT);
   endfunction

   task automatic clear_shadow_map();
      int b;
      shadow_used = 0;
      for (b = 0; b < NUM_BLK; b++) begin
         shadow_map[b] = is_reserved_blk(b);
         if (is_reserved_blk(b)) shadow_used++;
      end
   endtask

   // applies one command to the shadow map and returns the response it earns
   function automatic alloc_rsp_type allocate_outcome(input logic [CMD_W-1:0] op,
                                                      input logic [ID_W-1:0] id);
      alloc_rsp_type r;
      int            b;
      logic          found;
      r.status  = ST_OK;
      r.granted = '0;
      found     = 1'b0;
      if (op == CMD_ALLOC) begin
         r.status = ST_FULL;
         for (b = 0; b < NUM_BLK; b++) begin
            if (!found && !shadow_map[b]) begin
               found         = 1'b1;
               shadow_map[b] = 1'b1;
               shadow_used++;
               r.granted     = GRANT_W'(b);
               r.status      = ST_OK;
            end
         end
      end else if (op == CMD_REQUEST) begin
         if (id >= NUM_BLK) r.status = ST_RANGE;
         else if (shadow_map[id]) r.status = ST_USED;
         else begin
            shadow_map[id] = 1'b1;
            shadow_used++;
         end
      end else if (op == CMD_RELEASE) begin
         if (id >= NUM_BLK) r.status = ST_RANGE;
         else if (is_reserved_blk(int'(id))) r.status = ST_RESERVED;
         else if (shadow_map[id]) begin
            shadow_map[id] = 1'b0;
            shadow_used--;
         end
      end else begin
         r.status = ST_RANGE;
      end
      r.used = COUNT_W'(shadow_used);
      r.free = COUNT_W'(NUM_BLK - shadow_used);
      return r;
   endfunction

   task automatic queue_cmd(input logic [CMD_W-1:0] op, input int id, input logic hold);
      cmd_item_type it;
      it.hold = hold;
      it.op   = op;
      it.id   = ID_W'(id);
      cmd_backlog.push_back(it);
   endtask

   // mostly in range, now and then past the end of the map
   function automatic int pick_blk_id();
      if ($urandom_range(0, 7) == 0) return $urandom_range(NUM_BLK, ID_MAX);
      return $urandom_range(0, NUM_BLK - 1);
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // sender: bursts with gaps, holding a held item until all responses are back
   always @(negedge clock) begin : drive_req
      cmd_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (cmd_backlog.size() != 0 &&
                      (!cmd_backlog[0].hold || awaited_rsp.size() == 0)) begin
            it = cmd_backlog.pop_front();
            req_tdata  <= {{(REQ_DATA_W - CMD_W - ID_W){1'b0}}, it.id, it.op};
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern changes mode after a random span
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 120);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= stall_span[2];
      endcase
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin : watch
      alloc_rsp_type want;
      if (reset) begin
         clear_shadow_map();
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            rsps_seen++;
            if (rsp_tdata[2:0] < 5) status_seen[rsp_tdata[2:0]]++;
            if (awaited_rsp.size() == 0) begin
               $display("%0t ns: response with none awaited, expected none, got %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status", int'(want.status), int'(rsp_tdata[2:0]));
               check_field("granted_block", int'(want.granted), int'(rsp_tdata[11:3]));
               check_field("used_count", int'(want.used), int'(rsp_tdata[21:12]));
               check_field("free_count", int'(want.free), int'(rsp_tdata[31:22]));
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_rsp.push_back(allocate_outcome(req_tdata[1:0], req_tdata[11:2]));
            cmds_sent++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog expired with %0d responses outstanding",
                     $time, awaited_rsp.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int  n;
      int  r;
      // directed: reserved block, range limits, unused code
      queue_cmd(CMD_ALLOC, ID_MAX, 1'b0);
      queue_cmd(CMD_ALLOC, 0, 1'b0);
      queue_cmd(CMD_REQUEST, RES_FIRST, 1'b0);
      queue_cmd(CMD_REQUEST, NUM_BLK - 1, 1'b0);
      queue_cmd(CMD_REQUEST, NUM_BLK, 1'b0);
      queue_cmd(CMD_REQUEST, ID_MAX, 1'b0);
      queue_cmd(CMD_REQUEST, NUM_BLK - 1, 1'b0);
      queue_cmd(CMD_RELEASE, RES_FIRST, 1'b0);
      queue_cmd(CMD_RELEASE, ID_MAX, 1'b0);
      queue_cmd(CMD_RELEASE, NUM_BLK, 1'b0);
      queue_cmd(CMD_RELEASE, 300, 1'b0);
      queue_cmd(CMD_RELEASE, NUM_BLK - 1, 1'b0);
      queue_cmd(CMD_RELEASE, 1, 1'b0);
      queue_cmd(CMD_ALLOC, 682, 1'b0);
      queue_cmd(CMD_UNUSED, 0, 1'b0);
      queue_cmd(CMD_UNUSED, ID_MAX, 1'b0);
      queue_cmd(CMD_REQUEST, 256, 1'b0);
      queue_cmd(CMD_RELEASE, 2, 1'b0);
      queue_cmd(CMD_REQUEST, 341, 1'b0);
      queue_cmd(CMD_ALLOC, 0, 1'b0);
      // fill phase: mostly allocates, runs the map into full
      for (n = 0; n < 600; n++) begin
         r = $urandom_range(0, 99);
         if (r < 94) queue_cmd(CMD_ALLOC, $urandom_range(0, ID_MAX), n == 0);
         else if (r < 97) queue_cmd(CMD_REQUEST, pick_blk_id(), n == 0);
         else queue_cmd(CMD_RELEASE, pick_blk_id(), n == 0);
      end
      // drain phase: mostly releases
      for (n = 0; n < 250; n++) begin
         r = $urandom_range(0, 99);
         if (r < 70) queue_cmd(CMD_RELEASE, pick_blk_id(), n == 0);
         else if (r < 85) queue_cmd(CMD_ALLOC, $urandom_range(0, ID_MAX), n == 0);
         else if (r < 95) queue_cmd(CMD_REQUEST, pick_blk_id(), n == 0);
         else queue_cmd(CMD_UNUSED, $urandom_range(0, ID_MAX), n == 0);
      end
      // mixed phase
      for (n = 0; n < 200; n++) begin
         r = $urandom_range(0, 99);
         if (r < 35) queue_cmd(CMD_ALLOC, $urandom_range(0, ID_MAX), n == 0);
         else if (r < 65) queue_cmd(CMD_REQUEST, pick_blk_id(), n == 0);
         else if (r < 95) queue_cmd(CMD_RELEASE, pick_blk_id(), n == 0);
         else queue_cmd(CMD_UNUSED, $urandom_range(0, ID_MAX), n == 0);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (cmd_backlog.size() == 0 && !req_tvalid);
      wait (awaited_rsp.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d commands sent, %0d responses checked, %0d mismatches",
               cmds_sent, rsps_seen, fail_count);
      $display("status ok %0d, full %0d, range %0d, used %0d, reserved %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
               status_seen[ST_USED], status_seen[ST_RESERVED]);
      if (fail_count == 0 && awaited_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
